FILE: design/nsc_pkg.sv
// Shared constants, codes and the loose hex digit decode for the NMEA sentence checker.
package nsc_pkg;

  // Widths of the beat fields
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned RecvW   = 13;
  localparam int unsigned DigitW  = 9;
  localparam int unsigned CountW  = 32;

  localparam logic [PosW-1:0] MAX_POSITION_RESET = 7'd100;
  localparam logic [PosW-1:0] POS_SAT            = 7'd127;

  // Parser phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_CONTENT  = 2'd1;
  localparam logic [1:0] PH_CHECKSUM = 2'd2;
  localparam logic [1:0] PH_COMPLETE = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] ST_NONE     = 2'd0;
  localparam logic [StatusW-1:0] ST_VALID    = 2'd1;
  localparam logic [StatusW-1:0] ST_MISMATCH = 2'd2;

  // Characters of interest
  localparam logic [ByteW-1:0] CHAR_LF     = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_BANG   = 8'h21;
  localparam logic [ByteW-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [ByteW-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [ByteW-1:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [ByteW-1:0] CASE_OFFSET = 8'h20;

  // Loose hex decode: lower case raised, no validation. Range -48..200.
  function automatic logic signed [DigitW-1:0] loose_digit(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] u;
    u = b;
    if (b >= CHAR_LO_A && b <= CHAR_LO_Z) begin
      u = b - CASE_OFFSET;
    end
    if (u >= CHAR_UP_A) begin
      loose_digit = $signed({1'b0, u} - 9'd55);
    end else begin
      loose_digit = $signed({1'b0, u} - 9'd48);
    end
  endfunction

endpackage

FILE: design/nsc_byte_if.sv
// Input channel: one received byte per beat.
interface nsc_byte_if
  import nsc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/nsc_result_if.sv
// Output channel: one status beat per received byte.
interface nsc_result_if
  import nsc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [PosW-1:0]          sentence_length;
  logic [ByteW-1:0]         computed_checksum;
  logic signed [RecvW-1:0]  received_checksum;
  logic [CountW-1:0]        valid_count;
  logic [CountW-1:0]        error_count;

  modport source (
    output valid, output status, output sentence_length, output computed_checksum,
    output received_checksum, output valid_count, output error_count, input ready
  );
  modport sink (
    input valid, input status, input sentence_length, input computed_checksum,
    input received_checksum, input valid_count, input error_count, output ready
  );
endinterface

FILE: design/nmea_sentence_checker_unit.sv
// NMEA 0183 sentence framer and checksum checker, one byte per beat.
//
// Usage:
//   in_byte  : valid/ready channel of raw serial bytes.
//   out_res  : valid/ready channel, exactly one beat per input byte, carrying
//              status (none / valid sentence / checksum mismatch), framed
//              length, computed and received checksum, and the wrapping
//              good/bad sentence counters after that byte.
//   cfg_we_i / cfg_wdata_i : writes max_position (reset value 100); write only
//              while no byte is in flight.
// Path: an accepted byte waits in the input register, is parsed by the next-state
//   logic into the result register and is presented on out_res from there.
// Throughput: one byte per cycle while out_res is ready; each parse is a single pass
//   through the input register, the next-state logic and the result register.
// Stall: the input register and the result register each hold one beat, so one
//   more byte is taken while a result waits; in_byte.ready then drops until
//   out_res.ready returns.
// Reset: parser idle, position, XOR and both counters zero, both stages empty.
module nmea_sentence_checker_unit
  import nsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PosW-1:0]   cfg_wdata_i,
  nsc_byte_if.sink          in_byte,
  nsc_result_if.source      out_res
);

  // Stages and handshake
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic             advance;
  logic             step;

  // Parser state
  logic [PosW-1:0]          max_pos_q;
  logic [1:0]               phase_q, phase_d, phase_w;
  logic [PosW-1:0]          pos_q, pos_d, pos_inc;
  logic [PosW-1:0]          clen_q, clen_d;
  logic [ByteW-1:0]         xor_q, xor_d;
  logic signed [DigitW-1:0] high_q, high_d, digit;
  logic [CountW-1:0]        good_q, good_d, bad_q, bad_d;

  // Result fields
  logic [StatusW-1:0]      status_d, status_q;
  logic [PosW-1:0]         len_d, len_q;
  logic [ByteW-1:0]        comp_d, comp_q;
  logic signed [RecvW-1:0] recv_d, recv_q;
  logic [PosW:0]           clen_p4, clen_p6, clen_p7;

  assign advance      = !out_valid_q || out_res.ready;
  assign step         = in_valid_q && advance;
  assign in_byte.ready = !in_valid_q || advance;

  assign digit   = loose_digit(in_byte_q);
  assign pos_inc = (pos_q == POS_SAT) ? POS_SAT : pos_q + 7'd1;
  assign clen_p4 = {1'b0, clen_q} + 8'd4;
  assign clen_p6 = {1'b0, clen_q} + 8'd6;
  assign clen_p7 = {1'b0, clen_q} + 8'd7;

  always_comb begin
    phase_w  = phase_q;
    if (pos_q >= max_pos_q) begin
      phase_w = PH_IDLE;
    end
    if (in_byte_q == CHAR_LF || in_byte_q == CHAR_CR) begin
      phase_w = PH_IDLE;
    end
    phase_d  = phase_w;
    pos_d    = pos_q;
    clen_d   = clen_q;
    xor_d    = xor_q;
    high_d   = high_q;
    good_d   = good_q;
    bad_d    = bad_q;
    status_d = ST_NONE;
    len_d    = '0;
    comp_d   = '0;
    recv_d   = '0;

    if (in_byte_q == CHAR_DOLLAR || in_byte_q == CHAR_BANG) begin
      // a start byte always reopens a sentence
      pos_d   = 7'd1;
      xor_d   = '0;
      clen_d  = '0;
      phase_d = PH_CONTENT;
    end else begin
      case (phase_w)
        PH_CONTENT: begin
          pos_d = pos_inc;
          if (in_byte_q == CHAR_STAR) begin
            phase_d = PH_CHECKSUM;
            clen_d  = (pos_inc >= 7'd2) ? pos_inc - 7'd2 : '0;
          end else begin
            xor_d = xor_q ^ in_byte_q;
          end
        end
        PH_CHECKSUM: begin
          pos_d = pos_inc;
          if ({1'b0, pos_inc} >= clen_p4) begin
            // second digit: decide
            recv_d = $signed({high_q, 4'b0000}) + $signed({{(RecvW-DigitW){digit[DigitW-1]}}, digit});
            comp_d = xor_q;
            if (recv_d != $signed({{(RecvW-ByteW){1'b0}}, xor_q})) begin
              status_d = ST_MISMATCH;
              bad_d    = bad_q + 32'd1;
              phase_d  = PH_IDLE;
            end else begin
              status_d = ST_VALID;
              len_d    = clen_p6[PosW] ? POS_SAT : clen_p6[PosW-1:0];
              good_d   = good_q + 32'd1;
              phase_d  = PH_COMPLETE;
            end
            pos_d = clen_p7[PosW] ? POS_SAT : clen_p7[PosW-1:0];
          end else begin
            high_d = digit;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q   <= MAX_POSITION_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      clen_q      <= '0;
      xor_q       <= '0;
      high_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_pos_q <= cfg_wdata_i;
      end
      if (in_byte.ready) begin
        in_valid_q <= in_byte.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        clen_q  <= clen_d;
        xor_q   <= xor_d;
        high_q  <= high_d;
        good_q  <= good_d;
        bad_q   <= bad_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_byte.valid && in_byte.ready) begin
      in_byte_q <= in_byte.rx_byte;
    end
    if (step) begin
      status_q <= status_d;
      len_q    <= len_d;
      comp_q   <= comp_d;
      recv_q   <= recv_d;
    end
  end

  assign out_res.valid             = out_valid_q;
  assign out_res.status            = status_q;
  assign out_res.sentence_length   = len_q;
  assign out_res.computed_checksum = comp_q;
  assign out_res.received_checksum = recv_q;
  assign out_res.valid_count       = good_q;
  assign out_res.error_count       = bad_q;

`ifndef SYNTHESIS
  // Completion phase is entered exactly when a good sentence is reported
  a_complete_iff_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> ((phase_d == PH_COMPLETE) == (status_d == ST_VALID)))
    else $error("completion phase and valid status disagree");

  // Good counter moves by one per valid status and never otherwise
  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> good_q == $past(good_q) + (($past(status_d) == ST_VALID) ? 32'd1 : 32'd0))
    else $error("good sentence count out of step with status");

  // Bad counter moves by one per mismatch status and never otherwise
  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> bad_q == $past(bad_q) + (($past(status_d) == ST_MISMATCH) ? 32'd1 : 32'd0))
    else $error("bad sentence count out of step with status");

  // A quiet beat carries zero length and checksums; a valid one has a framed length
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_NONE) |->
      (len_q == '0 && comp_q == '0 && recv_q == '0))
    else $error("nonzero fields on a beat with no status");

  a_valid_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_VALID) |-> len_q >= 7'd6)
    else $error("valid sentence with short framed length");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the NMEA sentence checker: directed table, then random byte streams.
module testbench;
  import nsc_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned BytesPerPhase = 175;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned LongHoldOff   = 60;
  localparam logic [ByteW-1:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic [PosW-1:0]         sentence_length;
    logic [ByteW-1:0]        computed_checksum;
    logic signed [RecvW-1:0] received_checksum;
    logic [CountW-1:0]       valid_count;
    logic [CountW-1:0]       error_count;
  } sentence_result_t;

  // lit rows carry a hand-written status/length/checksums; counters always come from the predictor
  typedef struct packed {
    logic [ByteW-1:0]        rx;
    bit                      lit;
    logic [StatusW-1:0]      status;
    logic [PosW-1:0]         sentence_length;
    logic [ByteW-1:0]        computed_checksum;
    logic signed [RecvW-1:0] received_checksum;
  } directed_row_t;

  localparam directed_row_t DirectedRows [27] = '{
    '{CHAR_DOLLAR, 1'b1, ST_NONE, 0, 0, 0},
    '{"A", 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{"4", 1'b0, ST_NONE, 0, 0, 0},
    '{"1", 1'b1, ST_VALID, 7, 8'h41, 65},
    '{CHAR_CR, 1'b1, ST_NONE, 0, 0, 0},
    // lower case digit, mismatch
    '{CHAR_BANG, 1'b0, ST_NONE, 0, 0, 0},
    '{"B", 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{"4", 1'b0, ST_NONE, 0, 0, 0},
    '{"a", 1'b1, ST_MISMATCH, 0, 8'h42, 74},
    // extreme content bytes, mixed case digits
    '{CHAR_DOLLAR, 1'b0, ST_NONE, 0, 0, 0},
    '{8'hFF, 1'b0, ST_NONE, 0, 0, 0},
    '{8'h00, 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{"f", 1'b0, ST_NONE, 0, 0, 0},
    '{"F", 1'b1, ST_VALID, 8, 8'hFF, 255},
    // any non-start byte after completion drops back to idle
    '{"U", 1'b1, ST_NONE, 0, 0, 0},
    // empty body, most negative decode
    '{CHAR_DOLLAR, 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{8'h00, 1'b0, ST_NONE, 0, 0, 0},
    '{8'h00, 1'b1, ST_MISMATCH, 0, 8'h00, -816},
    // star decoded as a digit
    '{CHAR_DOLLAR, 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b0, ST_NONE, 0, 0, 0},
    '{CHAR_STAR, 1'b1, ST_MISMATCH, 0, 8'h00, -102},
    '{CHAR_LF, 1'b1, ST_NONE, 0, 0, 0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [PosW-1:0] cfg_wdata_i;

  nsc_byte_if   byte_ch ();
  nsc_result_if result_ch ();

  nmea_sentence_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte     (byte_ch),
    .out_res     (result_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state, starts at reset values
  logic [1:0]       parse_phase     = PH_IDLE;
  int               parse_pos       = 0;
  int               body_len        = 0;
  logic [ByteW-1:0] xor_acc         = '0;
  int               high_digit_val  = 0;
  logic [CountW-1:0] good_count     = '0;
  logic [CountW-1:0] bad_count      = '0;
  int               pos_limit       = int'(MAX_POSITION_RESET);

  sentence_result_t pending_status [$];
  int unsigned      mismatches = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      sender_idle_pct = 0;
  int unsigned      receiver_idle_pct = 0;
  bit               long_stall_due = 1'b0;

  function automatic int hex_value(input logic [ByteW-1:0] b);
    int v;
    v = int'(b);
    if (b >= CHAR_LO_A && b <= CHAR_LO_Z) v = v - int'(CASE_OFFSET);
    if (v >= int'(CHAR_UP_A)) return v - int'(CHAR_UP_A) + 10;
    return v - int'(CHAR_ZERO);
  endfunction

  function automatic int bump(input int p);
    return (p >= int'(POS_SAT)) ? int'(POS_SAT) : p + 1;
  endfunction

  function automatic sentence_result_t parse_byte(input logic [ByteW-1:0] c);
    sentence_result_t r;
    int recv;
    r = '0;
    // the start byte test wins over both the limit and the line ending
    if (parse_pos >= pos_limit) parse_phase = PH_IDLE;
    if (c == CHAR_LF || c == CHAR_CR) parse_phase = PH_IDLE;
    if (c == CHAR_DOLLAR || c == CHAR_BANG) begin
      parse_pos   = 1;
      xor_acc     = '0;
      body_len    = 0;
      parse_phase = PH_CONTENT;
    end else if (parse_phase == PH_CONTENT) begin
      parse_pos = bump(parse_pos);
      if (c == CHAR_STAR) begin
        parse_phase = PH_CHECKSUM;
        body_len    = (parse_pos >= 2) ? parse_pos - 2 : 0;
      end else begin
        xor_acc = xor_acc ^ c;
      end
    end else if (parse_phase == PH_CHECKSUM) begin
      parse_pos = bump(parse_pos);
      if (parse_pos >= body_len + 4) begin
        recv = high_digit_val * 16 + hex_value(c);
        r.computed_checksum = xor_acc;
        r.received_checksum = RecvW'(recv);
        if (recv != int'(xor_acc)) begin
          r.status    = ST_MISMATCH;
          bad_count   = bad_count + 1;
          parse_phase = PH_IDLE;
        end else begin
          r.status          = ST_VALID;
          r.sentence_length = PosW'((body_len + 6 > int'(POS_SAT)) ? int'(POS_SAT)
                                                                  : body_len + 6);
          good_count        = good_count + 1;
          parse_phase       = PH_COMPLETE;
        end
        parse_pos = (body_len + 7 > int'(POS_SAT)) ? int'(POS_SAT) : body_len + 7;
      end else begin
        high_digit_val = hex_value(c);
      end
    end else begin
      parse_phase = PH_IDLE;
    end
    r.valid_count = good_count;
    r.error_count = bad_count;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_byte(input logic [ByteW-1:0] b, input bit use_lit = 1'b0,
                           input directed_row_t row = '0);
    sentence_result_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    r = parse_byte(b);
    if (use_lit) begin
      r.status            = row.status;
      r.sentence_length   = row.sentence_length;
      r.computed_checksum = row.computed_checksum;
      r.received_checksum = row.received_checksum;
    end
    pending_status.push_back(r);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] content_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255));
    while (b == CHAR_DOLLAR || b == CHAR_BANG || b == CHAR_STAR || b == CHAR_CR ||
           b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CHAR_ZERO + ByteW'(nib);
    return ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + ByteW'(nib) - 8'd10;
  endfunction

  task automatic send_sentence();
    int kind;
    int n;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_byte($urandom_range(0, 1) ? CHAR_DOLLAR : CHAR_BANG);
      // now and then a body long enough to run into the position limit
      n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
      sum = '0;
      repeat (n) begin
        b = content_byte();
        sum = sum ^ b;
        send_byte(b);
      end
      send_byte(CHAR_STAR);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(ByteW'($urandom_range(0, 255)));
        send_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
      end
      if ($urandom_range(0, 1)) begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
    end else if (kind < 85) begin
      send_byte($urandom_range(0, 1) ? CHAR_DOLLAR : CHAR_BANG);
      repeat ($urandom_range(0, 5)) send_byte(content_byte());
      repeat ($urandom_range(0, 4)) send_byte(ByteW'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  // only while nothing is in flight
  task automatic write_max_position(input logic [PosW-1:0] v);
    byte_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    pos_limit = int'(v);
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // receiver: random ready, plus one long hold-off while the sender keeps pushing
  initial begin
    int hold_left;
    bit long_stall_done;
    hold_left       = 0;
    long_stall_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_due && !long_stall_done) begin
        hold_left       = LongHoldOff;
        long_stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sentence_result_t want;
    sentence_result_t got;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got.status            = result_ch.status;
      got.sentence_length   = result_ch.sentence_length;
      got.computed_checksum = result_ch.computed_checksum;
      got.received_checksum = result_ch.received_checksum;
      got.valid_count       = result_ch.valid_count;
      got.error_count       = result_ch.error_count;
      if (pending_status.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d", $time, got.status);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", want.status, got.status);
        if (got.sentence_length !== want.sentence_length)
          report_mismatch("sentence_length", want.sentence_length, got.sentence_length);
        if (got.computed_checksum !== want.computed_checksum)
          report_mismatch("computed_checksum", want.computed_checksum, got.computed_checksum);
        if (got.received_checksum !== want.received_checksum)
          report_mismatch("received_checksum", want.received_checksum, got.received_checksum);
        if (got.valid_count !== want.valid_count)
          report_mismatch("valid_count", want.valid_count, got.valid_count);
        if (got.error_count !== want.error_count)
          report_mismatch("error_count", want.error_count, got.error_count);
      end
    end
  end

  // watchdog on cycles without any beat on either side
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    logic [PosW-1:0] limits [NumPhases];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    limits = '{7'd100, 7'd127, 7'd4, 7'd0, 7'd2, PosW'($urandom_range(5, 126))};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_max_position(limits[ph]);
      // sender-light/receiver-heavy, then swapped, then no idling
      sender_idle_pct   = (ph < 2) ? 14 : (ph < 4) ? 50 : 0;
      receiver_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 14 : 0;
      if (ph == 4) long_stall_due = 1'b1;
      if (ph == 0) begin
        foreach (DirectedRows[i]) send_byte(DirectedRows[i].rx, DirectedRows[i].lit,
                                            DirectedRows[i]);
      end
      target = bytes_sent + BytesPerPhase;
      while (bytes_sent < target) send_sentence();
    end
    byte_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/nsc_pkg.sv
design/nsc_byte_if.sv
design/nsc_result_if.sv
design/nmea_sentence_checker_unit.sv
test/testbench.sv
